/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RDQ_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RDQ_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rdq_pkg.sv */
package rdq_pkg;

	// Sizes
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int ST_W      = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TRAVERSE   = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_DENIED = 2'd3;

	// Mode values
	localparam logic MODE_INPUT  = 1'b0;
	localparam logic MODE_OUTPUT = 1'b1;

	// Register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] out_value;
		logic                     last;
	} res_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load_cmd;
		logic res_load_stat;
		logic rd_issue;
		logic rd_next;
		logic res_load_data;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic imm;
		logic trav_more;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/core/restricted_deque.sv */
// Channel | Direction | Payload        | Handshake
// cmd     | in        | cmd_item_t     | cmd_valid / cmd_stall
// res     | out       | res_item_t     | res_valid / res_stall
// cfg     | in        | restrict_mode  | APB psel / penable / pwrite
//
// One command at a time. Push and every refused command: a status result, no memory read.
// Pop: the result comes from the registered read of the slot memory.
// Traverse: one memory read and one result per cycle while the result side is not stalled.
// Reset clears mode, front index, fill count and the output register; slots are not cleared.
// A stalled result holds the controller; the next command is taken while a result waits.
module restricted_deque #(
	parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rdq_pkg::PADDR_W-1:0]   paddr,
	input  logic [rdq_pkg::PDATA_W-1:0]   pwdata,
	output logic [rdq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  rdq_pkg::cmd_item_t            cmd_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output rdq_pkg::res_item_t            res_data
);

	import rdq_pkg::*;

	logic     mode_q;
	ctl_t     ctl;
	dp_stat_t st;

	// Mode register write on APB transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INPUT;
		end else if (psel && penable && pwrite && (paddr == ADDR_MODE)) begin
			mode_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

	rdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.st        (st),
		.ctl       (ctl)
	);

	rdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd_data  (cmd_data),
		.mode      (mode_q),
		.res_stall (res_stall),
		.st        (st),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

endmodule

/* rtl/core/rdq_ram.sv */
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/rdq_ctrl.sv */
module rdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  rdq_pkg::dp_stat_t st,
	output rdq_pkg::ctl_t     ctl
);

	import rdq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DATA = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Sequence one command: take it, decide, then emit from memory if needed
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load_cmd = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.imm) begin
					if (st.out_free) begin
						ctl.res_load_stat = 1'b1;
						state_d           = S_IDLE;
					end
				end else begin
					ctl.rd_issue = 1'b1;
					state_d      = S_DATA;
				end
			end
			S_DATA: begin
				if (st.out_free) begin
					ctl.res_load_data = 1'b1;
					if (st.trav_more) begin
						ctl.rd_next = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);

endmodule

/* rtl/core/rdq_dp.sv */
module rdq_dp #(
	parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rdq_pkg::ctl_t      ctl,
	input  rdq_pkg::cmd_item_t cmd_data,
	input  logic               mode,
	input  logic               res_stall,
	output rdq_pkg::dp_stat_t  st,
	output logic               res_valid,
	output rdq_pkg::res_item_t res_data
);

	import rdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  trav_q;
	res_item_t         res_q;
	logic              res_valid_q;

	logic              is_push;
	logic              is_pop;
	logic              is_trav;
	logic              denied;
	logic              full;
	logic              empty;
	logic [ST_W-1:0]   dec_status;
	logic              push_ok;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  raddr;
	logic              re;
	logic [DATA_W-1:0] rdata;

	// Ring index a + b, with a below DEPTH and b at most DEPTH
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + {1'b0, b};
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// Decode the held command against mode and fill level
	always_comb begin
		is_push = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
		is_pop  = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
		is_trav = (cmd_q == CMD_TRAVERSE);
		denied  = !(is_push || is_pop || is_trav) ||
			((cmd_q == CMD_PUSH_FRONT) && (mode == MODE_INPUT)) ||
			((cmd_q == CMD_POP_BACK) && (mode == MODE_OUTPUT));
		full    = (fill_q == CNT_W'(DEPTH));
		empty   = (fill_q == '0);
		if (denied) begin
			dec_status = ST_DENIED;
		end else if (is_push) begin
			dec_status = full ? ST_FULL : ST_OK;
		end else begin
			dec_status = empty ? ST_EMPTY : ST_OK;
		end
	end

	assign st.imm       = denied || is_push || empty;
	assign st.trav_more = is_trav && ((CNT_W'(trav_q) + CNT_W'(1)) != fill_q);
	assign st.out_free  = !res_valid_q || !res_stall;

	// Write side: push lands before the front or after the back
	assign push_ok   = ctl.res_load_stat && is_push && !denied && !full;
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign waddr     = (cmd_q == CMD_PUSH_FRONT) ? front_dec : wrap_add(front_q, fill_q);

	// Read side: first access of a pop or traverse, or the next traverse slot
	always_comb begin
		if (ctl.rd_next) begin
			raddr = wrap_add(front_q, CNT_W'(trav_q) + CNT_W'(1));
		end else if (cmd_q == CMD_POP_BACK) begin
			raddr = wrap_add(front_q, fill_q - CNT_W'(1));
		end else begin
			raddr = front_q;
		end
	end

	assign re = ctl.rd_issue || ctl.rd_next;

	rdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (waddr),
		.wdata (val_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Hold the accepted command
	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			cmd_q <= cmd_data.cmd;
			val_q <= cmd_data.push_value;
		end
	end

	// Advance ring pointers and traverse position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
			trav_q  <= '0;
		end else begin
			if (push_ok) begin
				fill_q <= fill_q + CNT_W'(1);
				if (cmd_q == CMD_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end
			if (ctl.rd_issue) begin
				trav_q <= '0;
				if (cmd_q == CMD_POP_FRONT) begin
					front_q <= wrap_add(front_q, CNT_W'(1));
					fill_q  <= fill_q - CNT_W'(1);
				end else if (cmd_q == CMD_POP_BACK) begin
					fill_q <= fill_q - CNT_W'(1);
				end
			end
			if (ctl.rd_next) begin
				trav_q <= trav_q + IDX_W'(1);
			end
		end
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.res_load_stat || ctl.res_load_data) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load_stat) begin
			res_q.status    <= dec_status;
			res_q.out_value <= '0;
			res_q.last      <= 1'b1;
		end else if (ctl.res_load_data) begin
			res_q.status    <= ST_OK;
			res_q.out_value <= rdata;
			res_q.last      <= !st.trav_more;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

/* rtl/core/rdq_checker.sv */
`include "assert_macros.svh"

module rdq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [rdq_pkg::PADDR_W-1:0] paddr,
	input logic [rdq_pkg::PDATA_W-1:0] pwdata,
	input logic [rdq_pkg::PDATA_W-1:0] prdata,
	input logic                        pready,
	input logic                        cmd_valid,
	input logic                        cmd_stall,
	input rdq_pkg::cmd_item_t          cmd_data,
	input logic                        res_valid,
	input logic                        res_stall,
	input rdq_pkg::res_item_t          res_data
);

	import rdq_pkg::*;

	logic res_held;
	logic res_fail;
	logic res_mid;
	logic cmd_held;
	logic mode_wr;
	logic mode_rd;

	// Terms used by the checks below
	assign res_held = res_valid && res_stall;
	assign res_fail = res_valid && (res_data.status != ST_OK);
	assign res_mid  = res_valid && !res_data.last;
	assign cmd_held = cmd_valid && cmd_stall;
	assign mode_rd  = (paddr == ADDR_MODE);
	assign mode_wr  = psel && penable && pwrite && pready && mode_rd;

	// A stalled result stays and keeps its payload
	`RDQ_NEXT(a_res_hold, res_held, res_valid && $stable(res_data), "stalled result changed")

	// A stalled command stays and keeps its payload
	`RDQ_NEXT(a_cmd_hold, cmd_held, cmd_valid && $stable(cmd_data), "stalled command changed")

	// Any failure status is a single, last result carrying zero
	`RDQ_IMPLY(a_fail_shape, res_fail, res_data.last && (res_data.out_value == '0), "bad failure")

	// An unfinished traverse keeps the command side closed
	`RDQ_IMPLY(a_trav_blocks, res_mid, cmd_stall && (res_data.status == ST_OK), "traverse open")

	// A mode write reads back on the next cycle
	`RDQ_NEXT(a_mode_rb, mode_wr, !mode_rd || (prdata[0] == $past(pwdata[0])), "mode read back")

endmodule

bind restricted_deque rdq_checker u_rdq_checker (.*);

/* dv/restricted_deque_tb.sv */
module restricted_deque_tb;
	import rdq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 36;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	cmd_item_t          cmd_data  = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_item_t          res_data;

	restricted_deque #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the deque contents and mode
	logic signed [DATA_W-1:0] ring [DEPTH];
	int unsigned              head = 0;
	int unsigned              fill = 0;
	logic                     mode = MODE_INPUT;

	cmd_item_t   cmd_queue[$];
	res_item_t   expected_q[$];
	res_item_t   want;
	bit          quiet = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic cmd_item_t make_cmd(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] word);
		cmd_item_t c;
		c.cmd        = op;
		c.push_value = word;
		return c;
	endfunction

	// Apply one accepted command to the shadow deque and queue its results
	task automatic predict_deque(input cmd_item_t c);
		res_item_t r;
		r        = '0;
		r.status = ST_OK;
		r.last   = 1'b1;
		if (c.cmd > CMD_TRAVERSE || (c.cmd == CMD_PUSH_FRONT && mode == MODE_INPUT) ||
				(c.cmd == CMD_POP_BACK && mode == MODE_OUTPUT)) begin
			r.status = ST_DENIED;
			expected_q.push_back(r);
		end else if (c.cmd == CMD_PUSH_FRONT || c.cmd == CMD_PUSH_BACK) begin
			if (fill >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (c.cmd == CMD_PUSH_FRONT) begin
					head       = (head + DEPTH - 1) % DEPTH;
					ring[head] = c.push_value;
				end else begin
					ring[(head + fill) % DEPTH] = c.push_value;
				end
				fill++;
			end
			expected_q.push_back(r);
		end else if (fill == 0) begin
			r.status = ST_EMPTY;
			expected_q.push_back(r);
		end else if (c.cmd == CMD_POP_FRONT) begin
			r.out_value = ring[head];
			head        = (head + 1) % DEPTH;
			fill--;
			expected_q.push_back(r);
		end else if (c.cmd == CMD_POP_BACK) begin
			r.out_value = ring[(head + fill - 1) % DEPTH];
			fill--;
			expected_q.push_back(r);
		end else begin
			// traverse: front to back, last flag on the final element
			for (int unsigned i = 0; i < fill; i++) begin
				r.out_value = ring[(head + i) % DEPTH];
				r.last      = (i + 1 == fill);
				expected_q.push_back(r);
			end
		end
	endtask

	// Block until everything sent has come back, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		while (cmd_queue.size() != 0 || cmd_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the mode register: setup cycle, then access cycle
	task automatic write_mode(input logic m);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MODE;
		pwdata  <= {31'($urandom()), m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mode    = m;
	endtask

	// Command driver: predict on each transfer, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_data  <= '0;
			send_gap  <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				predict_deque(cmd_data);
			if (cmd_valid && cmd_stall) begin
				// hold the stalled transfer
			end else if (send_gap > 0) begin
				send_gap  <= send_gap - 1;
				cmd_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				cmd_valid <= 1'b1;
				cmd_data  <= cmd_queue.pop_front();
				send_gap  <= idle_span();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result monitor: check each transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d value %0d last %0b",
							res_data.status, res_data.out_value, res_data.last);
				end else begin
					want = expected_q.pop_front();
					if (res_data.status !== want.status ||
							res_data.out_value !== want.out_value ||
							res_data.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: status %0d/%0d value %0d/%0d last %0b/%0b",
								want.status, res_data.status, want.out_value,
								res_data.out_value, want.last, res_data.last);
					end
				end
			end
			// stall in random bursts
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res_stall  <= 1'b1;
			end else begin
				stall_left <= idle_span();
				res_stall  <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		int unsigned kind;
		logic [CMD_W-1:0] op;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset mode (input restricted): empty, denied, extremes
		cmd_queue.push_back(make_cmd(CMD_POP_FRONT, '0));
		cmd_queue.push_back(make_cmd(CMD_TRAVERSE, '0));
		cmd_queue.push_back(make_cmd(CMD_POP_BACK, '0));
		cmd_queue.push_back(make_cmd(CMD_PUSH_FRONT, 32'sd5));
		cmd_queue.push_back(make_cmd(3'd5, '1));
		cmd_queue.push_back(make_cmd(3'd7, '0));
		cmd_queue.push_back(make_cmd(CMD_PUSH_BACK, 32'sh7fffffff));
		cmd_queue.push_back(make_cmd(CMD_PUSH_BACK, 32'sh80000000));
		cmd_queue.push_back(make_cmd(CMD_PUSH_BACK, '1));
		cmd_queue.push_back(make_cmd(CMD_TRAVERSE, '0));
		cmd_queue.push_back(make_cmd(CMD_POP_BACK, '0));
		cmd_queue.push_back(make_cmd(CMD_POP_FRONT, '0));
		settle();

		// Directed, output restricted
		write_mode(MODE_OUTPUT);
		cmd_queue.push_back(make_cmd(CMD_POP_BACK, '0));
		cmd_queue.push_back(make_cmd(CMD_PUSH_FRONT, '0));
		cmd_queue.push_back(make_cmd(CMD_PUSH_FRONT, 32'sh55555555));
		cmd_queue.push_back(make_cmd(CMD_PUSH_BACK, 32'shaaaaaaaa));
		cmd_queue.push_back(make_cmd(3'd6, 32'sh12345678));
		cmd_queue.push_back(make_cmd(CMD_TRAVERSE, '0));
		repeat (5) cmd_queue.push_back(make_cmd(CMD_POP_FRONT, '0));
		settle();

		// Random phases: fill and drain bursts, traverses, some noise
		for (int p = 0; p < PHASES; p++) begin
			write_mode(p[0] ? MODE_OUTPUT : MODE_INPUT);
			quiet = (p == 2 || p == 5);
			sent  = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(0, 99);
				if (kind < 35) begin
					burst = $urandom_range(1, 20);
					repeat (burst) begin
						if (mode == MODE_OUTPUT && $urandom_range(0, 1))
							op = CMD_PUSH_FRONT;
						else
							op = CMD_PUSH_BACK;
						cmd_queue.push_back(make_cmd(op, pick_word()));
					end
					sent += burst;
				end else if (kind < 65) begin
					burst = $urandom_range(1, 20);
					repeat (burst) begin
						if (mode == MODE_INPUT && $urandom_range(0, 1))
							op = CMD_POP_BACK;
						else
							op = CMD_POP_FRONT;
						cmd_queue.push_back(make_cmd(op, pick_word()));
					end
					sent += burst;
				end else if (kind < 80) begin
					cmd_queue.push_back(make_cmd(CMD_TRAVERSE, pick_word()));
					sent++;
				end else begin
					cmd_queue.push_back(make_cmd(3'($urandom_range(0, 7)), pick_word()));
					sent++;
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
